// ===== rtl/biq_pkg.sv =====
// biquad filter package: field widths, digit-serial multiplier sizes,
// register index codes and the lane control struct
// no dependencies
package biq_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC      = COEF_BITS - 4;
   localparam int STATE_BITS     = SAMPLE_BITS + COEF_BITS;
   localparam int SUM_BITS       = STATE_BITS + 2;
   localparam int DIGIT_BITS     = 4;
   localparam int DIGIT_COUNT    = SAMPLE_BITS / DIGIT_BITS;
   localparam int CNT_BITS       = $clog2(DIGIT_COUNT);
   localparam int PP_BITS        = COEF_BITS + DIGIT_BITS + 1;
   localparam int HI_BITS        = COEF_BITS + 2;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [CSR_INDEX_BITS-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_A2 = 3'd4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [STATE_BITS-1:0]  state_type;

   typedef struct packed {
      logic start;
      logic step;
      logic last;
   } lane_ctl_type;

endpackage

// ===== rtl/biq_req_if.sv =====
// input channel of the biquad filter: one sample word per handshake
// depends on biq_pkg
interface biq_req_if;
   logic                 valid;
   logic                 ready;
   biq_pkg::sample_type  sample_in;
   logic                 clear_state;

   modport source (output valid, output sample_in, output clear_state, input ready);
   modport sink   (input valid, input sample_in, input clear_state, output ready);
endinterface

// ===== rtl/biq_rsp_if.sv =====
// result channel of the biquad filter: one filtered sample word per handshake
// depends on biq_pkg
interface biq_rsp_if;
   logic                 valid;
   logic                 ready;
   biq_pkg::sample_type  sample_out;
   logic                 clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== rtl/biquad_iir_filter.sv =====
// biquad iir section, transposed direct form ii, with digit-serial multipliers
// depends on biq_pkg, biq_req_if, biq_rsp_if, biq_lane
//
// usage:
//   req_chan carries one signed sample word plus a clear_state flag; clear_state
//   zeroes both delay words before that sample is filtered.
//   rsp_chan returns one word per sample: the output rounded half up, clamped to
//   sample range, and clipped set when the clamp hit.
//   csr_we/csr_index/csr_wdata write coefficients b0, b1, b2, a1, a2 (indices 0
//   to 4, signed q3.28); other indices are ignored. write only while idle.
// sequence:
//   one sample at a time. three multiplier lanes work the 24-bit sample in
//   six 4-bit digits (b0, b1, b2 times x), then two lanes work the output
//   sample (a1, a2 times y). states in order: MUL1, SUMY, SATY, MUL2, UPD;
//   a new sample is taken only after UPD returns the block to idle.
// reset: synchronous, active high; clears coefficients, delay words and the
//   output valid flag.
// stall: the result sits in an output register; a stalled receiver holds the
//   block in its final step until the output register frees up.
module biquad_iir_filter (
   input  logic                                clock,
   input  logic                                reset,
   biq_req_if.sink                             req_chan,
   biq_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [biq_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [biq_pkg::COEF_BITS-1:0]       csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_SUMY = 3'd2;
   localparam logic [2:0] ST_SATY = 3'd3;
   localparam logic [2:0] ST_MUL2 = 3'd4;
   localparam logic [2:0] ST_UPD  = 3'd5;

   localparam int YW_BITS  = biq_pkg::SUM_BITS - biq_pkg::COEF_FRAC;
   localparam int YTOP     = YW_BITS - biq_pkg::SAMPLE_BITS + 1;
   localparam int NTOP     = biq_pkg::SUM_BITS - biq_pkg::STATE_BITS + 1;
   localparam logic [biq_pkg::CNT_BITS-1:0] CNT_LAST = biq_pkg::CNT_BITS'(biq_pkg::DIGIT_COUNT - 1);
   localparam logic signed [biq_pkg::SUM_BITS-1:0] HALF =
      biq_pkg::SUM_BITS'(1) <<< (biq_pkg::COEF_FRAC - 1);

   logic [2:0]                          state_ff, state_in;
   logic [biq_pkg::CNT_BITS-1:0]        cnt_ff, cnt_in;
   biq_pkg::coef_type                   b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;
   biq_pkg::state_type                  d1_ff, d2_ff;
   logic signed [biq_pkg::SUM_BITS-1:0] accy_ff, accy_in;
   logic signed [biq_pkg::SUM_BITS-1:0] t1_ff, t1_in;
   logic signed [biq_pkg::SUM_BITS-1:0] n1, n2;
   biq_pkg::state_type                  n1_sat, n2_sat;
   logic signed [YW_BITS-1:0]           y_wide;
   biq_pkg::sample_type                 yq_in, yq_ff;
   logic                                clip_in, clip_ff;
   logic                                rsp_valid_ff;
   biq_pkg::sample_type                 rsp_sample_ff;
   logic                                rsp_clip_ff;
   logic                                accept, out_free, leave;
   logic                                cnt_last;
   biq_pkg::lane_ctl_type               ctl_ab, ctl_c;
   biq_pkg::coef_type                   coef0, coef1;
   biq_pkg::sample_type                 opnd_ab;
   biq_pkg::state_type                  prod0, prod1, prod2;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign leave    = (state_ff == ST_UPD) && out_free;
   assign cnt_last = (cnt_ff == CNT_LAST);

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_sample_ff;
   assign rsp_chan.clipped    = rsp_clip_ff;

   // lane control and operand selection
   always_comb begin
      ctl_ab.start = accept || (state_ff == ST_SATY);
      ctl_ab.step  = (state_ff == ST_MUL1) || (state_ff == ST_MUL2);
      ctl_ab.last  = cnt_last;
      ctl_c.start  = accept;
      ctl_c.step   = (state_ff == ST_MUL1);
      ctl_c.last   = cnt_last;
      if (state_ff == ST_IDLE) begin
         coef0   = b0_ff;
         coef1   = b1_ff;
         opnd_ab = req_chan.sample_in;
      end else begin
         coef0   = a1_ff;
         coef1   = a2_ff;
         opnd_ab = yq_in;
      end
   end

   biq_lane u_lane0 (
      .clock   (clock),
      .ctl     (ctl_ab),
      .coef    (coef0),
      .operand (opnd_ab),
      .product (prod0)
   );

   biq_lane u_lane1 (
      .clock   (clock),
      .ctl     (ctl_ab),
      .coef    (coef1),
      .operand (opnd_ab),
      .product (prod1)
   );

   biq_lane u_lane2 (
      .clock   (clock),
      .ctl     (ctl_c),
      .coef    (b2_ff),
      .operand (req_chan.sample_in),
      .product (prod2)
   );

   // output rounding, clamp, state update
   always_comb begin
      accy_in = biq_pkg::SUM_BITS'(prod0) + biq_pkg::SUM_BITS'(d1_ff) + HALF;
      t1_in   = biq_pkg::SUM_BITS'(d2_ff) + biq_pkg::SUM_BITS'(prod1);
      y_wide  = $signed(accy_ff[biq_pkg::SUM_BITS-1:biq_pkg::COEF_FRAC]);
      if ((&y_wide[YW_BITS-1 -: YTOP]) || !(|y_wide[YW_BITS-1 -: YTOP])) begin
         yq_in   = y_wide[biq_pkg::SAMPLE_BITS-1:0];
         clip_in = 1'b0;
      end else begin
         yq_in   = {y_wide[YW_BITS-1], {(biq_pkg::SAMPLE_BITS-1){!y_wide[YW_BITS-1]}}};
         clip_in = 1'b1;
      end
      n1 = t1_ff - biq_pkg::SUM_BITS'(prod0);
      n2 = biq_pkg::SUM_BITS'(prod2) - biq_pkg::SUM_BITS'(prod1);
      if ((&n1[biq_pkg::SUM_BITS-1 -: NTOP]) || !(|n1[biq_pkg::SUM_BITS-1 -: NTOP])) begin
         n1_sat = n1[biq_pkg::STATE_BITS-1:0];
      end else begin
         n1_sat = {n1[biq_pkg::SUM_BITS-1], {(biq_pkg::STATE_BITS-1){!n1[biq_pkg::SUM_BITS-1]}}};
      end
      if ((&n2[biq_pkg::SUM_BITS-1 -: NTOP]) || !(|n2[biq_pkg::SUM_BITS-1 -: NTOP])) begin
         n2_sat = n2[biq_pkg::STATE_BITS-1:0];
      end else begin
         n2_sat = {n2[biq_pkg::SUM_BITS-1], {(biq_pkg::STATE_BITS-1){!n2[biq_pkg::SUM_BITS-1]}}};
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = ST_SUMY;
               cnt_in   = '0;
            end
         end
         ST_SUMY: begin
            state_in = ST_SATY;
         end
         ST_SATY: begin
            state_in = ST_MUL2;
            cnt_in   = '0;
         end
         ST_MUL2: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               state_in = ST_UPD;
               cnt_in   = '0;
            end
         end
         ST_UPD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         d1_ff        <= '0;
         d2_ff        <= '0;
         b0_ff        <= '0;
         b1_ff        <= '0;
         b2_ff        <= '0;
         a1_ff        <= '0;
         a2_ff        <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (leave) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_chan.clear_state) begin
            d1_ff <= '0;
            d2_ff <= '0;
         end else if (leave) begin
            d1_ff <= n1_sat;
            d2_ff <= n2_sat;
         end
         if (csr_we) begin
            unique case (csr_index)
               biq_pkg::REG_B0: b0_ff <= csr_wdata;
               biq_pkg::REG_B1: b1_ff <= csr_wdata;
               biq_pkg::REG_B2: b2_ff <= csr_wdata;
               biq_pkg::REG_A1: a1_ff <= csr_wdata;
               biq_pkg::REG_A2: a2_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_SUMY) begin
         accy_ff <= accy_in;
         t1_ff   <= t1_in;
      end
      if (state_ff == ST_SATY) begin
         yq_ff   <= yq_in;
         clip_ff <= clip_in;
      end
      if (leave) begin
         rsp_sample_ff <= yq_ff;
         rsp_clip_ff   <= clip_ff;
      end
   end

endmodule

// ===== rtl/biq_lane.sv =====
// digit-serial multiplier lane: coefficient times sample, one 4-bit digit of
// the sample per step, lsb digit first, top digit signed
// depends on biq_pkg
module biq_lane (
   input  logic                  clock,
   input  biq_pkg::lane_ctl_type ctl,
   input  biq_pkg::coef_type     coef,
   input  biq_pkg::sample_type   operand,
   output biq_pkg::state_type    product
);

   biq_pkg::coef_type                     coef_ff;
   biq_pkg::sample_type                   opnd_ff;
   logic signed [biq_pkg::HI_BITS-1:0]    hi_ff;
   logic signed [biq_pkg::HI_BITS-1:0]    hi_in;
   logic [biq_pkg::SAMPLE_BITS-1:0]       lo_ff;
   logic signed [biq_pkg::DIGIT_BITS:0]   digit;
   logic signed [biq_pkg::PP_BITS-1:0]    pp;
   logic signed [biq_pkg::PP_BITS:0]      sum;

   always_comb begin
      if (ctl.last) begin
         digit = {opnd_ff[biq_pkg::DIGIT_BITS-1], opnd_ff[biq_pkg::DIGIT_BITS-1:0]};
      end else begin
         digit = {1'b0, opnd_ff[biq_pkg::DIGIT_BITS-1:0]};
      end
      pp    = biq_pkg::PP_BITS'(coef_ff) * biq_pkg::PP_BITS'(digit);
      sum   = (biq_pkg::PP_BITS + 1)'(hi_ff) + (biq_pkg::PP_BITS + 1)'(pp);
      hi_in = biq_pkg::HI_BITS'(sum >>> biq_pkg::DIGIT_BITS);
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         coef_ff <= coef;
         opnd_ff <= operand;
         hi_ff   <= '0;
         lo_ff   <= '0;
      end else if (ctl.step) begin
         opnd_ff <= opnd_ff >>> biq_pkg::DIGIT_BITS;
         hi_ff   <= hi_in;
         lo_ff   <= {sum[biq_pkg::DIGIT_BITS-1:0],
                     lo_ff[biq_pkg::SAMPLE_BITS-1:biq_pkg::DIGIT_BITS]};
      end
   end

   assign product = {hi_ff[biq_pkg::COEF_BITS-1:0], lo_ff};

endmodule

// ===== dv/tb.sv =====
// testbench for biquad_iir_filter: random and directed sample words against a
// fixed-point transposed direct form ii predictor, with random gaps on both channels
// depends on biq_pkg, biq_req_if, biq_rsp_if and the biquad_iir_filter rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import biq_pkg::*;

   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
   localparam longint STATE_HI  = (longint'(1) <<< (STATE_BITS - 1)) - 1;
   localparam longint STATE_LO  = -STATE_HI - 1;
   localparam longint HALF_LSB  = longint'(1) <<< (COEF_FRAC - 1);
   localparam int     ONE_Q     = 1 << COEF_FRAC;
   localparam int     REG_COUNT = 2 ** CSR_INDEX_BITS;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
   localparam coef_type   COEF_MAX   = {1'b0, {(COEF_BITS - 1){1'b1}}};
   localparam coef_type   COEF_MIN   = {1'b1, {(COEF_BITS - 1){1'b0}}};

   typedef enum int {COEF_MILD, COEF_FULL, COEF_EDGE} coef_mix_type;

   typedef struct {
      sample_type sample;
      logic       clear;
      bit         drain;
   } sample_word_type;

   typedef struct {
      sample_type sample_out;
      logic       clipped;
   } filtered_word_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COEF_BITS-1:0]      csr_wdata = '0;

   biq_req_if req_bus ();
   biq_rsp_if rsp_bus ();

   biquad_iir_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sample_word_type   pending_samples[$];
   filtered_word_type due_outputs[$];

   coef_type coef_bank[REG_COUNT];
   longint   delay_one_q = 0;
   longint   delay_two_q = 0;

   bit req_fired  = 1'b0;
   bit gaps_on    = 1'b1;
   int gap_left   = 0;
   int stall_left = 0;
   int err_count  = 0;
   int n_taken    = 0;
   int n_checked  = 0;
   int n_clipped  = 0;
   int n_cleared  = 0;
   int n_settings = 0;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.sample_in   = '0;
      req_bus.clear_state = 1'b0;
      rsp_bus.ready       = 1'b0;
      foreach (coef_bank[i]) coef_bank[i] = '0;
   end

   initial begin
      #4_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint clamp_state(input longint v);
      if (v > STATE_HI) return STATE_HI;
      if (v < STATE_LO) return STATE_LO;
      return v;
   endfunction

   // one filter step on the predictor's own state and coefficient copy
   function automatic filtered_word_type run_biquad(input sample_type x, input logic clr);
      filtered_word_type res;
      longint xs, acc, yq, n1, n2;
      xs = longint'(x);
      if (clr) begin
         delay_one_q = 0;
         delay_two_q = 0;
      end
      acc = longint'(coef_bank[REG_B0]) * xs + delay_one_q + HALF_LSB;
      acc = acc >>> COEF_FRAC;
      res.clipped = 1'b0;
      if (acc > SAMPLE_HI) begin
         yq = SAMPLE_HI;
         res.clipped = 1'b1;
      end else if (acc < SAMPLE_LO) begin
         yq = SAMPLE_LO;
         res.clipped = 1'b1;
      end else begin
         yq = acc;
      end
      n1 = delay_two_q + longint'(coef_bank[REG_B1]) * xs - longint'(coef_bank[REG_A1]) * yq;
      n2 = longint'(coef_bank[REG_B2]) * xs - longint'(coef_bank[REG_A2]) * yq;
      delay_one_q = clamp_state(n1);
      delay_two_q = clamp_state(n2);
      res.sample_out = sample_type'(yq);
      return res;
   endfunction

   // input driver
   always @(negedge clock) begin
      sample_word_type word;
      if (!reset && (!req_bus.valid || req_fired)) begin
         if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
         end else if (pending_samples.size() != 0 &&
                      !(pending_samples[0].drain && due_outputs.size() != 0)) begin
            word = pending_samples.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.sample_in   <= word.sample;
            req_bus.clear_state <= word.clear;
            gap_left = gaps_on ? pick_gap() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result receiver stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = gaps_on ? pick_gap() : 0;
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      filtered_word_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_outputs.size() == 0) begin
               $error("unexpected output word: sample_out %0d clipped %0b",
                      rsp_bus.sample_out, rsp_bus.clipped);
               err_count++;
            end else begin
               want = due_outputs.pop_front();
               n_checked++;
               if (rsp_bus.sample_out !== want.sample_out) begin
                  $error("sample_out mismatch: expected %0d, got %0d",
                         want.sample_out, rsp_bus.sample_out);
                  err_count++;
               end
               if (rsp_bus.clipped !== want.clipped) begin
                  $error("clipped mismatch: expected %0b, got %0b",
                         want.clipped, rsp_bus.clipped);
                  err_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = run_biquad(req_bus.sample_in, req_bus.clear_state);
            due_outputs.push_back(want);
            n_taken++;
            if (want.clipped) n_clipped++;
            if (req_bus.clear_state) n_cleared++;
         end
      end
   end

   task automatic set_coef(input logic [CSR_INDEX_BITS-1:0] idx, input coef_type val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx <= REG_A2) coef_bank[idx] = val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_all(input coef_type b0, input coef_type b1, input coef_type b2,
                          input coef_type a1, input coef_type a2);
      set_coef(REG_B0, b0);
      set_coef(REG_B1, b1);
      set_coef(REG_B2, b2);
      set_coef(REG_A1, a1);
      set_coef(REG_A2, a2);
      n_settings++;
   endtask

   task automatic settle();
      while (pending_samples.size() != 0 || due_outputs.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic void queue_sample(input sample_type s, input logic clr,
                                        input bit drain = 1'b0);
      sample_word_type word;
      word.sample = s;
      word.clear  = clr;
      word.drain  = drain;
      pending_samples.push_back(word);
   endfunction

   function automatic coef_type random_coef(input coef_mix_type mix);
      case (mix)
         COEF_MILD: return coef_type'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
         COEF_FULL: return coef_type'($urandom);
         default: begin
            case ($urandom_range(0, 6))
               0: return COEF_MAX;
               1: return COEF_MIN;
               2: return '0;
               3: return coef_type'(ONE_Q);
               4: return coef_type'(-ONE_Q);
               5: return coef_type'(1);
               default: return coef_type'(-1);
            endcase
         end
      endcase
   endfunction

   function automatic sample_type random_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return SAMPLE_MAX;
               1: return SAMPLE_MIN;
               2: return '0;
               3: return sample_type'(1);
               default: return sample_type'(-1);
            endcase
         end
         1, 2: return sample_type'(int'($urandom_range(0, 511)) - 256);
         default: return sample_type'($urandom);
      endcase
   endfunction

   initial begin
      coef_mix_type mix;
      int drain_at;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // coefficients still at reset: output is zero
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      settle();

      // unity passthrough; writes to unused indices must be dropped
      set_all(coef_type'(ONE_Q), '0, '0, '0, '0);
      for (int k = REG_A2 + 1; k < REG_COUNT; k++)
         set_coef(CSR_INDEX_BITS'(k), coef_type'($urandom));
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample('0, 1'b0);
      queue_sample(sample_type'(-1), 1'b0);
      queue_sample(sample_type'(1), 1'b0);
      settle();

      // half gain: rounding ties go up
      set_all(coef_type'(ONE_Q / 2), '0, '0, '0, '0);
      queue_sample(sample_type'(1), 1'b0);
      queue_sample(sample_type'(-1), 1'b0);
      queue_sample(sample_type'(3), 1'b0);
      queue_sample(sample_type'(-3), 1'b0);
      settle();

      // extreme coefficients: output clamp and state saturation
      set_all(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample('0, 1'b0);
      settle();

      // feedback path with state clear mid stream
      set_all(coef_type'(ONE_Q / 4), coef_type'(ONE_Q / 2), coef_type'(ONE_Q / 4),
              coef_type'(-ONE_Q / 2), coef_type'(ONE_Q / 4));
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample('0, 1'b0);
      queue_sample('0, 1'b0);
      queue_sample('0, 1'b0);
      queue_sample(sample_type'(100), 1'b1);
      queue_sample('0, 1'b0);
      settle();

      for (int phase = 0; phase < 13; phase++) begin
         mix     = coef_mix_type'(phase % 3);
         gaps_on = (phase % 4 != 1);
         set_all(random_coef(mix), random_coef(mix), random_coef(mix),
                 random_coef(mix), random_coef(mix));
         if (phase % 2 == 1)
            set_coef(CSR_INDEX_BITS'($urandom_range(REG_A2 + 1, REG_COUNT - 1)),
                     coef_type'($urandom));
         drain_at = $urandom_range(20, 130);
         for (int n = 0; n < 150; n++)
            queue_sample(random_sample(), $urandom_range(0, 19) == 0, n == drain_at);
         settle();
      end

      while (due_outputs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("ran %0d samples (%0d with state clear) through %0d coefficient settings",
               n_taken, n_cleared, n_settings);
      $display("checked %0d output words, %0d of them clamped", n_checked, n_clipped);
      if (err_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
